// ===== rtl/rgcd_pkg.sv =====
package rgcd_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int SHIFT_WIDTH = $clog2(VALUE_WIDTH);
	localparam int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [SHIFT_WIDTH-1:0] shift_t;
	typedef logic [TDATA_WIDTH-1:0] tdata_t;

	// request to the GCD unit
	typedef struct packed {
		logic   start;
		value_t a;
		value_t b;
	} rgcd_req_t;

	// response from the GCD unit
	typedef struct packed {
		logic   done;
		value_t result;
	} rgcd_rsp_t;

endpackage

// ===== rtl/rgcd_unit.sv =====
module rgcd_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  rgcd_pkg::rgcd_req_t req,
	output rgcd_pkg::rgcd_rsp_t rsp
);
	import rgcd_pkg::*;

	typedef enum logic [2:0] {
		U_IDLE    = 3'b001,
		U_REDUCE  = 3'b010,
		U_RESTORE = 3'b100
	} ustate_t;

	ustate_t state_q;
	value_t  a_q;
	value_t  b_q;
	shift_t  k_q;

	// binary GCD: one compare/subtract or shift per cycle, then shift the
	// common power of two back in one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						state_q <= U_REDUCE;
						k_q     <= '0;
					end
				end
				U_REDUCE: begin
					if (a_q == '0 || b_q == '0) begin
						state_q <= U_RESTORE;
					end else if (!a_q[0] && !b_q[0]) begin
						k_q <= k_q + 1'b1;
					end
				end
				U_RESTORE: begin
					if (k_q == '0) begin
						state_q <= U_IDLE;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	// operand datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				if (req.start) begin
					a_q <= req.a;
					b_q <= req.b;
				end
			end
			U_REDUCE: begin
				priority if (a_q == '0) begin
					a_q <= b_q;
				end else if (b_q == '0) begin
					a_q <= a_q;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q >= b_q) begin
					a_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
			U_RESTORE: begin
				if (k_q != '0) begin
					a_q <= a_q << 1;
				end
			end
			default: begin
				a_q <= a_q;
			end
		endcase
	end

	assign rsp.done   = (state_q == U_RESTORE) && (k_q == '0);
	assign rsp.result = a_q;

endmodule

// ===== rtl/running_gcd_reduction_core.sv =====
// An item is taken only in the idle state. None is reduced when it starts a set
// or the running GCD is already 1; any other item is reduced with the running
// GCD in the binary-GCD subtract/shift unit, and a last item then loads the output.
// No new item is taken until the unit and any output load for the last one are done.
// Reset (arst_n, async, active low) clears the running GCD to 0, marks the next
// item as the start of a set and empties the output register.
module running_gcd_reduction_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  rgcd_pkg::tdata_t s_tdata,  // [30:0] value, upper bits unused
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output rgcd_pkg::tdata_t m_tdata   // [30:0] set_gcd, upper bits zero
);
	import rgcd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CALC = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t    state_q;
	value_t    run_q;
	logic      first_q;
	logic      last_q;
	logic      out_vld_q;
	value_t    out_q;
	rgcd_req_t req;
	rgcd_rsp_t rsp;
	value_t    in_value;
	logic      in_xfer;
	logic      out_free;

	assign in_value = s_tdata[VALUE_WIDTH-1:0];
	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	// start the unit only when a real reduction is needed
	assign req.start = in_xfer && !first_q && (run_q != value_t'(1));
	assign req.a     = in_value;
	assign req.b     = run_q;

	rgcd_unit u_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			run_q     <= '0;
			first_q   <= 1'b1;
			last_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// output valid: set on a load, cleared on a transfer
			if (state_q == S_EMIT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						last_q <= s_tlast;
						if (first_q) begin
							run_q   <= in_value;
							first_q <= 1'b0;
							state_q <= s_tlast ? S_EMIT : S_IDLE;
						end else if (req.start) begin
							state_q <= S_CALC;
						end else begin
							state_q <= s_tlast ? S_EMIT : S_IDLE;
						end
					end
				end
				S_CALC: begin
					if (rsp.done) begin
						run_q   <= rsp.result;
						state_q <= last_q ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						run_q     <= '0;
						first_q   <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output holding register
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_q <= run_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = tdata_t'(out_q);

endmodule
